### hdl/ashkin_teller_metropolis_update_top_assert.svh
// assertion macros shared by the spin update modules
`ifndef ASHKIN_TELLER_METROPOLIS_UPDATE_TOP_ASSERT_SVH
`define ASHKIN_TELLER_METROPOLIS_UPDATE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ATMU_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ATMU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/atmu_pkg.sv
// shared constants and types of the ashkin-teller spin update block
`default_nettype none

package atmu_pkg;

   localparam int LATTICE_SIDE = 64;
   localparam int N_SITES      = LATTICE_SIDE * LATTICE_SIDE;
   localparam int ADDR_W       = $clog2(N_SITES);
   // reciprocal of the side for row/column split, one correction step after it
   localparam int RECIP        = (2 ** ADDR_W) / LATTICE_SIDE;

   localparam int SITE_W      = 12;
   localparam int FRAC_W      = 16;
   localparam int U_W         = 16;
   localparam int BOND_W      = 15;
   localparam int MAG_W       = 14;
   localparam int SPIN_W      = 2;
   localparam int IDX_W       = 3;
   localparam int TBL_ENTRIES = 25;
   localparam int TBL_IDX_W   = 5;
   localparam int SCALE_W     = 20;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 88;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_U_COUPLING     = 3'd0,
      CSR_ACCEPT_TABLE_0 = 3'd1,
      CSR_ACCEPT_TABLE_1 = 3'd2,
      CSR_ACCEPT_TABLE_2 = 3'd3,
      CSR_ACCEPT_TABLE_3 = 3'd4,
      CSR_ACCEPT_TABLE_4 = 3'd5,
      CSR_ACCEPT_TABLE_5 = 3'd6,
      CSR_ACCEPT_TABLE_6 = 3'd7
   } csr_index_type;

   // inputs of the acceptance decision; a_idx and b_idx are (a+4)/2 and (b+4)/2
   typedef struct packed {
      logic              flip_req;
      logic              in_range;
      logic              own_neg;
      logic              new_spin;
      logic [IDX_W-1:0]  a_idx;
      logic [IDX_W-1:0]  b_idx;
      logic [FRAC_W-1:0] rand_frac;
   } eval_type;

   // write-back of one item toward the running sums
   typedef struct packed {
      logic             valid;
      logic             flipped;
      logic             layer;
      logic [IDX_W-1:0] a_idx;
      logic [IDX_W-1:0] b_idx;
      logic             sigma_neg;
      logic             tau_neg;
   } update_type;

endpackage

`default_nettype wire

### hdl/atmu_ram.sv
// generic single write port ram with registered read
`default_nettype none

module atmu_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/atmu_cfg.sv
// coupling and acceptance table registers, metropolis acceptance decision
`default_nettype none

module atmu_cfg
   import atmu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire eval_type              eval_req,
   output logic                       accept
);

   logic [U_W-1:0]       u_ff;
   logic [FRAC_W-1:0]    tbl_ff [TBL_ENTRIES];
   logic [TBL_IDX_W-1:0] tbl_base;
   logic [TBL_IDX_W-1:0] tbl_idx;
   logic signed [3:0]    a_off;
   logic signed [3:0]    b_off;
   logic signed [SCALE_W-1:0] scaled;
   logic                 flip_ok;
   logic                 set_ok;

   // four entries per wide register, one in the last
   assign tbl_base = TBL_IDX_W'({csr_addr - 3'd1, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         u_ff <= '0;
         for (int k = 0; k < TBL_ENTRIES; k++) begin
            tbl_ff[k] <= '0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            CSR_U_COUPLING: begin
               u_ff <= csr_wdata[U_W-1:0];
            end
            CSR_ACCEPT_TABLE_0, CSR_ACCEPT_TABLE_1, CSR_ACCEPT_TABLE_2,
            CSR_ACCEPT_TABLE_3, CSR_ACCEPT_TABLE_4, CSR_ACCEPT_TABLE_5: begin
               for (int k = 0; k < 4; k++) begin
                  tbl_ff[tbl_base + TBL_IDX_W'(k)] <= csr_wdata[FRAC_W*k +: FRAC_W];
               end
            end
            CSR_ACCEPT_TABLE_6: begin
               tbl_ff[TBL_ENTRIES-1] <= csr_wdata[FRAC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // dE <= 0 test as (a/2)*256 + U*(b/2) <= 0
   always_comb begin
      a_off   = signed'({1'b0, eval_req.a_idx}) - 4'sd2;
      b_off   = signed'({1'b0, eval_req.b_idx}) - 4'sd2;
      scaled  = (SCALE_W'(a_off) <<< 8)
              + signed'({{(SCALE_W-U_W){1'b0}}, u_ff}) * SCALE_W'(b_off);
      tbl_idx = TBL_IDX_W'({eval_req.a_idx, 2'b00}) + TBL_IDX_W'(eval_req.a_idx)
              + TBL_IDX_W'(eval_req.b_idx);
      flip_ok = (scaled <= 0) || (eval_req.rand_frac < tbl_ff[tbl_idx]);
      set_ok  = eval_req.own_neg != eval_req.new_spin;
      accept  = eval_req.in_range && (eval_req.flip_req ? flip_ok : set_ok);
   end

endmodule

`default_nettype wire

### hdl/atmu_seq.sv
// item sequencer: spin memory, neighbour reads, decision capture, write-back
`default_nettype none

`include "ashkin_teller_metropolis_update_top_assert.svh"

module atmu_seq
   import atmu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output eval_type                   eval_req,
   input  wire logic                  accept,
   output update_type                 upd,
   input  wire logic                  upd_ready
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_ADDR  = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_LAST  = 7'b0010000,
      ST_EVAL  = 7'b0100000,
      ST_WRITE = 7'b1000000
   } state_type;

   localparam logic [1:0] NBR_RIGHT = 2'd0;
   localparam logic [1:0] NBR_LEFT  = 2'd1;
   localparam logic [1:0] NBR_DOWN  = 2'd2;
   localparam logic [1:0] NBR_UP    = 2'd3;
   localparam int RW = ADDR_W + 2;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              rd_pend_ff, rd_pend_in;

   logic                  flip_req_ff;
   logic                  layer_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [FRAC_W-1:0]     rand_ff;
   logic                  new_spin_ff;
   logic                  in_range_ff;
   logic [2*ADDR_W-1:0]   prod_ff;
   logic                  col_first_ff, col_last_ff, row_first_ff, row_last_ff;
   logic                  sigma_neg_ff, tau_neg_ff;
   logic [IDX_W-1:0]      own_cnt_ff, cross_cnt_ff;
   logic                  flipped_ff;

   logic                  req_fire;
   logic                  upd_fire;
   logic                  req_layer;
   logic [SITE_W-1:0]     req_site;
   logic [FRAC_W-1:0]     req_frac;
   logic                  req_new_spin;
   logic [ADDR_W-1:0]     req_addr;
   logic [ADDR_W-1:0]     q_est;
   logic [RW-1:0]         rem;
   logic                  corr;
   logic [RW-1:0]         col;
   logic [RW-1:0]         row;
   logic [ADDR_W-1:0]     nbr_addr;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [SPIN_W-1:0]     ram_wr_data;
   logic                  ram_we;
   logic [SPIN_W-1:0]     ram_rd_data;
   logic                  own_neg;

   // tdata from bit 0: layer, site, random_fraction, new_spin
   assign req_layer    = req_tdata[0];
   assign req_site     = req_tdata[12:1];
   assign req_frac     = req_tdata[28:13];
   assign req_new_spin = req_tdata[29];
   assign req_addr     = ADDR_W'(req_site);

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign upd_fire   = upd.valid && upd_ready;

   // row/column edge flags from the reciprocal estimate
   always_comb begin
      q_est = prod_ff[2*ADDR_W-1:ADDR_W];
      rem   = RW'(addr_ff) - RW'(RW'(q_est) * RW'(LATTICE_SIDE));
      corr  = rem >= RW'(LATTICE_SIDE);
      col   = corr ? rem - RW'(LATTICE_SIDE) : rem;
      row   = RW'(q_est) + RW'(corr);
   end

   always_comb begin
      case (cnt_ff)
         NBR_RIGHT: nbr_addr = col_last_ff  ? addr_ff - ADDR_W'(LATTICE_SIDE - 1)
                                            : addr_ff + ADDR_W'(1);
         NBR_LEFT:  nbr_addr = col_first_ff ? addr_ff + ADDR_W'(LATTICE_SIDE - 1)
                                            : addr_ff - ADDR_W'(1);
         NBR_DOWN:  nbr_addr = row_last_ff  ? addr_ff - ADDR_W'(N_SITES - LATTICE_SIDE)
                                            : addr_ff + ADDR_W'(LATTICE_SIDE);
         NBR_UP:    nbr_addr = row_first_ff ? addr_ff + ADDR_W'(N_SITES - LATTICE_SIDE)
                                            : addr_ff - ADDR_W'(LATTICE_SIDE);
         default:   nbr_addr = addr_ff;
      endcase
   end

   assign ram_rd_addr = (state_ff == ST_IDLE) ? req_addr : nbr_addr;
   assign ram_we      = (state_ff == ST_CLEAR) || (upd_fire && flipped_ff);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0
                      : {tau_neg_ff ^ layer_ff, sigma_neg_ff ^ !layer_ff};

   atmu_ram #(
      .WIDTH (SPIN_W),
      .DEPTH (N_SITES)
   ) u_spin_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      rd_pend_in = state_ff == ST_READ;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(N_SITES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == NBR_UP) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (upd_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         flip_req_ff  <= !req_tuser;
         layer_ff     <= req_layer;
         addr_ff      <= req_addr;
         rand_ff      <= req_frac;
         new_spin_ff  <= req_new_spin;
         in_range_ff  <= 32'(req_site) < N_SITES;
         prod_ff      <= (2*ADDR_W)'(req_addr) * (2*ADDR_W)'(RECIP);
         own_cnt_ff   <= '0;
         cross_cnt_ff <= '0;
      end else if (rd_pend_ff) begin
         own_cnt_ff   <= own_cnt_ff + IDX_W'(layer_ff ? ram_rd_data[1] : ram_rd_data[0]);
         cross_cnt_ff <= cross_cnt_ff + IDX_W'(ram_rd_data[0] ^ ram_rd_data[1]);
      end
      if (state_ff == ST_ADDR) begin
         sigma_neg_ff <= ram_rd_data[0];
         tau_neg_ff   <= ram_rd_data[1];
         col_first_ff <= col == '0;
         col_last_ff  <= col == RW'(LATTICE_SIDE - 1);
         row_first_ff <= row == '0;
         row_last_ff  <= row == RW'(LATTICE_SIDE - 1);
      end
      if (state_ff == ST_EVAL) begin
         flipped_ff <= accept;
      end
   end

   assign own_neg = layer_ff ? tau_neg_ff : sigma_neg_ff;

   always_comb begin
      eval_req.flip_req  = flip_req_ff;
      eval_req.in_range  = in_range_ff;
      eval_req.own_neg   = own_neg;
      eval_req.new_spin  = new_spin_ff;
      eval_req.a_idx     = own_neg ? own_cnt_ff : IDX_W'(4) - own_cnt_ff;
      eval_req.b_idx     = (sigma_neg_ff ^ tau_neg_ff) ? cross_cnt_ff
                                                       : IDX_W'(4) - cross_cnt_ff;
      eval_req.rand_frac = rand_ff;
      upd.valid          = state_ff == ST_WRITE;
      upd.flipped        = flipped_ff;
      upd.layer          = layer_ff;
      upd.a_idx          = eval_req.a_idx;
      upd.b_idx          = eval_req.b_idx;
      upd.sigma_neg      = sigma_neg_ff;
      upd.tau_neg        = tau_neg_ff;
   end

   `ATMU_ASSERT_SAME(a_wr_only_on_flip, ram_we && (state_ff != ST_CLEAR),
      upd_fire && upd.flipped, "spin write without an accepted flip")
   `ATMU_ASSERT_NEXT(a_fire_to_addr, req_fire, state_ff == ST_ADDR,
      "accepted transaction did not start address phase")
   `ATMU_ASSERT_SAME(a_count_range, state_ff == ST_EVAL,
      (own_cnt_ff <= IDX_W'(4)) && (cross_cnt_ff <= IDX_W'(4)),
      "neighbour count beyond four")

endmodule

`default_nettype wire

### hdl/ashkin_teller_metropolis_update_top.sv
// top level of the ashkin-teller metropolis spin update block
//
//   channel | dir | handshake          | payload
//   req     | in  | req_tvalid/tready  | tdata: layer, site, random_fraction, new_spin;
//           |     |                    | tuser: req_type
//   rsp     | out | rsp_tvalid/tready  | tdata: flipped and six running sums
//   csr     | in  | csr_we             | csr_addr register index, csr_wdata value
//
// one item steps through accept, row/column split, four neighbour reads on the
// single spin memory read port, last read data, decision, write-back.
// after reset a clearing pass writes every spin to +1, one site a cycle; req_tready
// stays low during it. the result sits in an output register; a write-back waits
// while it is not taken.
`default_nettype none

`include "ashkin_teller_metropolis_update_top_assert.svh"

module ashkin_teller_metropolis_update_top
   import atmu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // bit 0 layer, 12:1 site, 28:13 random_fraction, 29 new_spin
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // bit 0 req_type
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // bit 0 flipped, 15:1 sigma_bond_sum, 30:16 tau_bond_sum, 45:31 quad_bond_sum,
   // 59:46 sigma_mag_sum, 73:60 tau_mag_sum, 87:74 baxter_mag_sum
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   eval_type   eval_req;
   update_type upd;
   logic       accept;
   logic       upd_ready;
   logic       upd_fire;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     flipped_ff, flipped_in;
   logic signed [BOND_W-1:0] sigma_bond_ff, sigma_bond_in;
   logic signed [BOND_W-1:0] tau_bond_ff, tau_bond_in;
   logic signed [BOND_W-1:0] quad_bond_ff, quad_bond_in;
   logic signed [MAG_W-1:0]  sigma_mag_ff, sigma_mag_in;
   logic signed [MAG_W-1:0]  tau_mag_ff, tau_mag_in;
   logic signed [MAG_W-1:0]  baxter_mag_ff, baxter_mag_in;

   logic [BOND_W-1:0] bond_delta;
   logic [BOND_W-1:0] four_delta;

   atmu_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .eval_req  (eval_req),
      .accept    (accept)
   );

   atmu_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eval_req   (eval_req),
      .accept     (accept),
      .upd        (upd),
      .upd_ready  (upd_ready)
   );

   assign upd_ready = !rsp_valid_ff || rsp_tready;
   assign upd_fire  = upd.valid && upd_ready;

   // 2a = 4*a_idx - 8, 2b = 4*b_idx - 8
   assign bond_delta = BOND_W'({upd.a_idx, 2'b00}) - BOND_W'(8);
   assign four_delta = BOND_W'({upd.b_idx, 2'b00}) - BOND_W'(8);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      flipped_in    = flipped_ff;
      sigma_bond_in = sigma_bond_ff;
      tau_bond_in   = tau_bond_ff;
      quad_bond_in  = quad_bond_ff;
      sigma_mag_in  = sigma_mag_ff;
      tau_mag_in    = tau_mag_ff;
      baxter_mag_in = baxter_mag_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
         flipped_in   = upd.flipped;
         if (upd.flipped) begin
            if (!upd.layer) begin
               sigma_bond_in = sigma_bond_ff - bond_delta;
               sigma_mag_in  = sigma_mag_ff + (upd.sigma_neg ? MAG_W'(2) : -MAG_W'(2));
            end else begin
               tau_bond_in = tau_bond_ff - bond_delta;
               tau_mag_in  = tau_mag_ff + (upd.tau_neg ? MAG_W'(2) : -MAG_W'(2));
            end
            quad_bond_in  = quad_bond_ff - four_delta;
            // sigma*tau was +1 when both bits agree
            baxter_mag_in = baxter_mag_ff
                          + ((upd.sigma_neg ^ upd.tau_neg) ? MAG_W'(2) : -MAG_W'(2));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         flipped_ff    <= 1'b0;
         sigma_bond_ff <= BOND_W'(2 * N_SITES);
         tau_bond_ff   <= BOND_W'(2 * N_SITES);
         quad_bond_ff  <= BOND_W'(2 * N_SITES);
         sigma_mag_ff  <= MAG_W'(N_SITES);
         tau_mag_ff    <= MAG_W'(N_SITES);
         baxter_mag_ff <= MAG_W'(N_SITES);
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         flipped_ff    <= flipped_in;
         sigma_bond_ff <= sigma_bond_in;
         tau_bond_ff   <= tau_bond_in;
         quad_bond_ff  <= quad_bond_in;
         sigma_mag_ff  <= sigma_mag_in;
         tau_mag_ff    <= tau_mag_in;
         baxter_mag_ff <= baxter_mag_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {baxter_mag_ff, tau_mag_ff, sigma_mag_ff,
                        quad_bond_ff, tau_bond_ff, sigma_bond_ff, flipped_ff};

   `ATMU_ASSERT_NEXT(a_no_flip_holds_sums, upd_fire && !upd.flipped,
      $stable(sigma_bond_ff) && $stable(tau_bond_ff) && $stable(quad_bond_ff)
      && $stable(sigma_mag_ff) && $stable(tau_mag_ff) && $stable(baxter_mag_ff),
      "sums moved without a flip")
   `ATMU_ASSERT_NEXT(a_sigma_flip_keeps_tau, upd_fire && upd.flipped && !upd.layer,
      $stable(tau_mag_ff) && $stable(tau_bond_ff), "sigma flip changed tau sums")
   `ATMU_ASSERT_NEXT(a_flip_moves_baxter, upd_fire && upd.flipped,
      baxter_mag_ff != $past(baxter_mag_ff), "flip left baxter sum unchanged")

endmodule

`default_nettype wire

### sim/ashkin_teller_metropolis_update_top_tb.sv
// testbench for the ashkin-teller metropolis spin update block: directed table, random flips and sets
module ashkin_teller_metropolis_update_top_tb;
   import atmu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {REQ_FLIP = 1'b0, REQ_SET = 1'b1} req_kind_type;
   typedef enum logic {LAYER_SIGMA = 1'b0, LAYER_TAU = 1'b1} layer_type;
   typedef enum int {FILL_ZERO, FILL_FULL, FILL_RANDOM} table_fill_type;

   typedef struct packed {
      req_kind_type      kind;
      layer_type         layer;
      logic [SITE_W-1:0] site;
      logic [FRAC_W-1:0] rand_frac;
      logic              new_spin;
   } spin_req_type;

   typedef struct packed {
      logic                     flipped;
      logic signed [BOND_W-1:0] sigma_bond;
      logic signed [BOND_W-1:0] tau_bond;
      logic signed [BOND_W-1:0] quad_bond;
      logic signed [MAG_W-1:0]  sigma_mag;
      logic signed [MAG_W-1:0]  tau_mag;
      logic signed [MAG_W-1:0]  baxter_mag;
   } spin_rsp_type;

   typedef struct {
      spin_req_type item;
      bit           typed;
      spin_rsp_type want;
   } directed_row_type;

   localparam int HALF_PERIOD   = 10;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 460;
   localparam int N_PHASES      = 4;
   localparam int N_CSRS        = 8;

   localparam int             SEND_IDLE [N_PHASES]    = '{0, 61, 0, 15};
   localparam int             RECV_STALL [N_PHASES]   = '{0, 0, 61, 15};
   localparam logic [15:0]    PHASE_U [N_PHASES]      = '{16'h0100, 16'hFFFF, 16'h0080, 16'h0000};
   localparam bit             PHASE_RAND_U [N_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1};
   localparam table_fill_type PHASE_FILL [N_PHASES]   =
      '{FILL_RANDOM, FILL_FULL, FILL_RANDOM, FILL_RANDOM};

   localparam spin_rsp_type COLD_SUMS = '{1'b0, 15'sd8192, 15'sd8192, 15'sd8192,
                                          14'sd4096, 14'sd4096, 14'sd4096};
   localparam spin_rsp_type NO_SUMS   = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_addr = CSR_U_COUPLING;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [1:0]        spin_mem [N_SITES];
   int                sigma_bond_total, tau_bond_total, quad_bond_total;
   int                sigma_mag_total, tau_mag_total, baxter_mag_total;
   logic [U_W-1:0]    cfg_u;
   logic [FRAC_W-1:0] accept_frac [TBL_ENTRIES];

   spin_rsp_type expected_sums_q [$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           quiet_cycles = 0;

   // cold lattice: typed rows carry sums worked out from the reset sums
   directed_row_type directed_rows [21] = '{
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd0,    16'h0000, 1'b0}, 1'b1, COLD_SUMS},
      '{'{REQ_FLIP, LAYER_TAU,   12'd4095, 16'hFFFF, 1'b1}, 1'b1, COLD_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'd0,    16'hFFFF, 1'b0}, 1'b1, COLD_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'd0,    16'h0000, 1'b1}, 1'b1,
        '{1'b1, 15'sd8184, 15'sd8192, 15'sd8184, 14'sd4094, 14'sd4096, 14'sd4094}},
      '{'{REQ_SET,  LAYER_TAU,   12'd0,    16'h0000, 1'b1}, 1'b1,
        '{1'b1, 15'sd8184, 15'sd8184, 15'sd8192, 14'sd4094, 14'sd4094, 14'sd4096}},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd0,    16'h0000, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_TAU,   12'd0,    16'h0000, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd63,   16'h8000, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_TAU,   12'd4032, 16'h7FFF, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_TAU,   12'd4095, 16'h1234, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd4095, 16'hFFFF, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'd1,    16'h0000, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd64,   16'h0001, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'd2,    16'hFFFF, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_TAU,   12'd1,    16'h0000, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'd1,    16'hFFFF, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'd1,    16'h0000, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_TAU,   12'd0,    16'h0000, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_SIGMA, 12'hAAA,  16'h5555, 1'b1}, 1'b0, NO_SUMS},
      '{'{REQ_FLIP, LAYER_TAU,   12'h555,  16'hAAAA, 1'b0}, 1'b0, NO_SUMS},
      '{'{REQ_SET,  LAYER_SIGMA, 12'h555,  16'h0F0F, 1'b1}, 1'b0, NO_SUMS}
   };

   ashkin_teller_metropolis_update_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // metropolis decision and running-sum update for one request
   function automatic spin_rsp_type apply_spin_update(spin_req_type it);
      spin_rsp_type res;
      int row, col, si, ti, sj, tj, own_nbr, pair_sum, own, other, a, b, scaled, idx;
      int nb [4];
      bit take;
      take = 1'b0;
      if (int'(it.site) < N_SITES) begin
         row = int'(it.site) / LATTICE_SIDE;
         col = int'(it.site) % LATTICE_SIDE;
         nb[0] = row * LATTICE_SIDE + (col + 1) % LATTICE_SIDE;
         nb[1] = row * LATTICE_SIDE + (col + LATTICE_SIDE - 1) % LATTICE_SIDE;
         nb[2] = ((row + 1) % LATTICE_SIDE) * LATTICE_SIDE + col;
         nb[3] = ((row + LATTICE_SIDE - 1) % LATTICE_SIDE) * LATTICE_SIDE + col;
         si = spin_mem[it.site][0] ? -1 : 1;
         ti = spin_mem[it.site][1] ? -1 : 1;
         own_nbr = 0;
         pair_sum = 0;
         for (int k = 0; k < 4; k++) begin
            sj = spin_mem[nb[k]][0] ? -1 : 1;
            tj = spin_mem[nb[k]][1] ? -1 : 1;
            own_nbr += (it.layer == LAYER_TAU) ? tj : sj;
            pair_sum += sj * tj;
         end
         own = (it.layer == LAYER_TAU) ? ti : si;
         other = (it.layer == LAYER_TAU) ? si : ti;
         a = own * own_nbr;
         b = own * other * pair_sum;
         if (it.kind == REQ_FLIP) begin
            scaled = a * 256 + int'(cfg_u) * b;
            idx = ((a + 4) / 2) * 5 + (b + 4) / 2;
            take = (scaled <= 0) || (it.rand_frac < accept_frac[idx]);
         end else begin
            take = spin_mem[it.site][it.layer] != it.new_spin;
         end
         if (take) begin
            if (it.layer == LAYER_SIGMA) begin
               sigma_bond_total -= 2 * a;
               sigma_mag_total -= 2 * si;
            end else begin
               tau_bond_total -= 2 * a;
               tau_mag_total -= 2 * ti;
            end
            quad_bond_total -= 2 * b;
            baxter_mag_total -= 2 * si * ti;
            spin_mem[it.site][it.layer] = ~spin_mem[it.site][it.layer];
         end
      end
      res.flipped    = take;
      res.sigma_bond = sigma_bond_total[BOND_W-1:0];
      res.tau_bond   = tau_bond_total[BOND_W-1:0];
      res.quad_bond  = quad_bond_total[BOND_W-1:0];
      res.sigma_mag  = sigma_mag_total[MAG_W-1:0];
      res.tau_mag    = tau_mag_total[MAG_W-1:0];
      res.baxter_mag = baxter_mag_total[MAG_W-1:0];
      return res;
   endfunction

   // most requests land in a small patch across the periodic corner so neighbours vary
   function automatic spin_req_type make_random_request();
      spin_req_type it;
      int row, col;
      it.kind = ($urandom_range(99) < 70) ? REQ_FLIP : REQ_SET;
      it.layer = ($urandom_range(1) == 1) ? LAYER_TAU : LAYER_SIGMA;
      if ($urandom_range(99) < 75) begin
         row = (LATTICE_SIDE - 2 + int'($urandom_range(3))) % LATTICE_SIDE;
         col = (LATTICE_SIDE - 2 + int'($urandom_range(5))) % LATTICE_SIDE;
         it.site = SITE_W'(row * LATTICE_SIDE + col);
      end else begin
         it.site = SITE_W'($urandom_range(N_SITES - 1));
      end
      case ($urandom_range(9))
         0: it.rand_frac = '0;
         1: it.rand_frac = '1;
         default: it.rand_frac = FRAC_W'($urandom_range(65535));
      endcase
      it.new_spin = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic load_settings(input logic [U_W-1:0] u_val, input table_fill_type fill);
      cfg_u = u_val;
      for (int e = 0; e < TBL_ENTRIES; e++) begin
         case (fill)
            FILL_ZERO: accept_frac[e] = '0;
            FILL_FULL: accept_frac[e] = '1;
            default:   accept_frac[e] = FRAC_W'($urandom_range(65535));
         endcase
      end
      for (int i = 0; i < N_CSRS; i++) begin
         csr_index_type         idx;
         logic [CSR_DATA_W-1:0] val;
         idx = csr_index_type'(i);
         // junk in the unused upper bits must be ignored
         val = {$urandom, $urandom};
         if (idx == CSR_U_COUPLING) begin
            val[U_W-1:0] = u_val;
         end else if (idx == CSR_ACCEPT_TABLE_6) begin
            val[FRAC_W-1:0] = accept_frac[TBL_ENTRIES-1];
         end else begin
            for (int k = 0; k < 4; k++)
               val[16*k +: 16] = accept_frac[4 * (int'(idx) - int'(CSR_ACCEPT_TABLE_0)) + k];
         end
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= val;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input spin_req_type it, input bit typed, input spin_rsp_type want);
      spin_rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {2'b00, it.new_spin, it.rand_frac, it.site, it.layer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = apply_spin_update(it);
      expected_sums_q.insert(expected_sums_q.size(), typed ? want : pred);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_sums_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      spin_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.flipped    = rsp_tdata[0];
         got.sigma_bond = rsp_tdata[15:1];
         got.tau_bond   = rsp_tdata[30:16];
         got.quad_bond  = rsp_tdata[45:31];
         got.sigma_mag  = rsp_tdata[59:46];
         got.tau_mag    = rsp_tdata[73:60];
         got.baxter_mag = rsp_tdata[87:74];
         if (expected_sums_q.size() == 0) begin
            $error("result transaction with no request pending");
            mismatch_count++;
         end else begin
            want = expected_sums_q.pop_front();
            check_field("flipped", int'(want.flipped), int'(got.flipped));
            check_field("sigma_bond_sum", int'(want.sigma_bond), int'(got.sigma_bond));
            check_field("tau_bond_sum", int'(want.tau_bond), int'(got.tau_bond));
            check_field("quad_bond_sum", int'(want.quad_bond), int'(got.quad_bond));
            check_field("sigma_mag_sum", int'(want.sigma_mag), int'(got.sigma_mag));
            check_field("tau_mag_sum", int'(want.tau_mag), int'(got.tau_mag));
            check_field("baxter_mag_sum", int'(want.baxter_mag), int'(got.baxter_mag));
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // covers the clearing pass after reset as well as a hung pipeline
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [U_W-1:0] u_val;
      for (int s = 0; s < N_SITES; s++)
         spin_mem[s] = 2'b00;
      sigma_bond_total = 2 * N_SITES;
      tau_bond_total   = 2 * N_SITES;
      quad_bond_total  = 2 * N_SITES;
      sigma_mag_total  = N_SITES;
      tau_mag_total    = N_SITES;
      baxter_mag_total = N_SITES;
      cfg_u = '0;
      for (int e = 0; e < TBL_ENTRIES; e++)
         accept_frac[e] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_settings(16'h0000, FILL_ZERO);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < N_PHASES; p++) begin
         drain_results();
         u_val = PHASE_RAND_U[p] ? 16'($urandom_range(65535)) : PHASE_U[p];
         load_settings(u_val, PHASE_FILL[p]);
         send_idle_pct = SEND_IDLE[p];
         rsp_stall_pct = RECV_STALL[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the pipeline run dry once in the middle of the first phase
            if (p == 0 && n == PHASE_ITEMS / 2)
               drain_results();
            send_item(make_random_request(), 1'b0, NO_SUMS);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_sums_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
